>>> rtl/glq_pkg.sv
// Shared types, codes and constants of the glyph quad layout block.
package glq_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 512;

   // transaction kinds
   localparam logic [1:0] KIND_LOAD       = 2'd0;
   localparam logic [1:0] KIND_GLYPH      = 2'd1;
   localparam logic [1:0] KIND_NEW_STRING = 2'd2;

   localparam logic [15:0] LAYER_DEPTH = 16'd20000;

   // screen scale divisors: coordinate = trunc(px * 32767 / divisor)
   localparam logic [10:0] SCALE_DIV_X = 11'd960;
   localparam logic [10:0] SCALE_DIV_Y = 11'd540;

   // |px * 32767| < 2^30
   // x: |p| / 960 = ((|p| >> 6) * ceil(2^28 / 15)) >> 28, exact for |p| >> 6 < 2^24
   // y: |p| / 540 = ((|p| >> 2) * ceil(2^36 / 135)) >> 36, exact for |p| >> 2 < 2^28
   localparam logic [28:0] RECIP_X = 29'd17895698;
   localparam logic [28:0] RECIP_Y = 29'd509033162;

   typedef struct packed {
      logic [1:0]         kind;
      logic [8:0]         entry_index;
      logic [20:0]        codepoint;
      logic signed [15:0] glyph_offset_x;
      logic signed [15:0] glyph_offset_y;
      logic signed [15:0] glyph_width;
      logic signed [15:0] glyph_height;
      logic signed [15:0] glyph_advance;
      logic [15:0]        texture_left;
      logic [15:0]        texture_right;
      logic [15:0]        texture_top;
      logic [15:0]        texture_bottom;
   } glq_req_type;

   typedef struct packed {
      logic [2:0]         corner;
      logic [15:0]        vertex_x;
      logic [15:0]        vertex_y;
      logic [15:0]        vertex_z;
      logic [15:0]        vertex_s;
      logic [15:0]        vertex_t;
      logic               found;
      logic               last;
      logic signed [15:0] pen_after;
   } glq_rsp_type;

   typedef struct packed {
      logic [20:0]        code;
      logic signed [15:0] off_x;
      logic signed [15:0] off_y;
      logic signed [15:0] width;
      logic signed [15:0] height;
      logic signed [15:0] advance;
      logic [15:0]        tc_left;
      logic [15:0]        tc_right;
      logic [15:0]        tc_top;
      logic [15:0]        tc_bottom;
   } glq_entry_type;

   typedef struct packed {
      logic               go;
      logic               use_y;
      logic signed [15:0] px;
   } glq_div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quot;
   } glq_div_res_type;

endpackage

>>> rtl/glq_scale_div.sv
// Reciprocal scaler: low 16 bits of trunc(px * 32767 / 960 or 540), done is go via v0, v1, v2.
module glq_scale_div (
   input  logic                     clock,
   input  logic                     reset,
   input  glq_pkg::glq_div_ctl_type ctl,
   output glq_pkg::glq_div_res_type res
);

   logic               v0_ff, v0_in;
   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   logic signed [15:0] px_ff, px_in;
   logic               y0_ff, y0_in;
   logic [29:0]        mag_ff, mag_in;
   logic               neg1_ff, neg1_in;
   logic               y1_ff, y1_in;
   logic [56:0]        prod_ff, prod_in;
   logic               neg2_ff, neg2_in;
   logic               y2_ff, y2_in;

   logic signed [16:0] px_ext;
   logic [16:0]        apx;
   logic [31:0]        mag_w;
   logic [27:0]        mul_a;
   logic [28:0]        mul_b;
   logic [15:0]        q16;

   always_comb begin
      v0_in = ctl.go;
      v1_in = v0_ff;
      v2_in = v1_ff;

      px_in = ctl.go ? ctl.px : px_ff;
      y0_in = ctl.go ? ctl.use_y : y0_ff;

      // |px * 32767| = (|px| << 15) - |px|
      px_ext = {px_ff[15], px_ff};
      apx    = px_ff[15] ? 17'(-px_ext) : 17'(px_ext);
      mag_w  = ({15'd0, apx} << 15) - {15'd0, apx};

      mag_in  = v0_ff ? mag_w[29:0] : mag_ff;
      neg1_in = v0_ff ? px_ff[15] : neg1_ff;
      y1_in   = v0_ff ? y0_ff : y1_ff;

      mul_a   = y1_ff ? mag_ff[29:2] : {4'd0, mag_ff[29:6]};
      mul_b   = y1_ff ? glq_pkg::RECIP_Y : glq_pkg::RECIP_X;
      prod_in = v1_ff ? ({29'd0, mul_a} * {28'd0, mul_b}) : prod_ff;
      neg2_in = v1_ff ? neg1_ff : neg2_ff;
      y2_in   = v1_ff ? y1_ff : y2_ff;

      q16 = y2_ff ? prod_ff[51:36] : prod_ff[43:28];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      px_ff   <= px_in;
      y0_ff   <= y0_in;
      mag_ff  <= mag_in;
      neg1_ff <= neg1_in;
      y1_ff   <= y1_in;
      prod_ff <= prod_in;
      neg2_ff <= neg2_in;
      y2_ff   <= y2_in;
   end

   // truncation toward zero: negate the magnitude quotient
   assign res.done = v2_ff;
   assign res.quot = neg2_ff ? 16'(~q16 + 16'd1) : q16;

endmodule

>>> rtl/glyph_quad_layout_core.sv
// Glyph quad layout: glyph table, first-match search and six-vertex quad output.
//
// Input transactions are taken at a clock edge with start high and busy low.
// A load writes one table slot (slot zero and slots past the table are
// dropped) in the accept cycle, gives no result and leaves busy low. A glyph
// transaction scans the table from slot 1, one slot per cycle through the
// registered table read port, and stops at the first match, an empty slot or
// the table end. A hit then runs four coordinate scalings one after another
// through one shared reciprocal-multiply scaler and emits six vertices on
// consecutive cycles, one per rsp_strobe pulse, the last flagged.
// A miss gives a single result flagged not found. Codepoint zero answers in
// the cycle after accept and keeps busy low.
// Results are single-cycle strobes; the receiver cannot stall them.
// After reset the block clears every table slot, one slot per cycle, with
// busy high; the pen position resets to zero.
module glyph_quad_layout_core #(
   parameter int TABLE_DEPTH = glq_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  glq_pkg::glq_req_type req_data,
   output logic                 rsp_strobe,
   output glq_pkg::glq_rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_CALC   = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   localparam logic [1:0] OP_LEFT  = 2'd0;
   localparam logic [1:0] OP_RIGHT = 2'd1;
   localparam logic [1:0] OP_DOWN  = 2'd2;
   localparam logic [1:0] OP_UP    = 2'd3;

   localparam logic [2:0] CORNER_UPLEFT     = 3'd0;
   localparam logic [2:0] CORNER_DOWNLEFT   = 3'd1;
   localparam logic [2:0] CORNER_UPRIGHT    = 3'd2;
   localparam logic [2:0] CORNER_DOWNRIGHT  = 3'd3;
   localparam logic [2:0] CORNER_UPRIGHT2   = 3'd4;
   localparam logic [2:0] CORNER_DOWNLEFT2  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [AW-1:0]          scan_ff, scan_in;
   logic                   end_ff, end_in;
   logic                   cmp_ff, cmp_in;
   logic                   cmp_end_ff, cmp_end_in;
   logic [20:0]            cp_ff, cp_in;
   logic signed [15:0]     pen_ff, pen_in;
   glq_pkg::glq_entry_type ent_ff, ent_in;
   logic [1:0]             op_ff, op_in;
   logic [2:0]             corner_ff, corner_in;
   logic [15:0]            xl_ff, xl_in, xr_ff, xr_in;
   logic [15:0]            yd_ff, yd_in, yu_ff, yu_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   glq_pkg::glq_rsp_type   rsp_data_ff, rsp_data_in;

   glq_pkg::glq_entry_type mem [TABLE_DEPTH];
   glq_pkg::glq_entry_type rd_data_ff;
   glq_pkg::glq_entry_type mem_wd;
   logic [AW-1:0]          mem_wa;
   logic                   mem_we;
   logic                   mem_re;

   glq_pkg::glq_div_ctl_type div_ctl;
   glq_pkg::glq_div_res_type div_res;

   logic                   accept;
   logic                   load_ok;
   logic signed [15:0]     left, right, down, up, pen_next, pen_eff;
   logic                   is_left, is_up;

   assign accept  = start && (state_ff == ST_IDLE);
   assign load_ok = accept && (req_data.kind == glq_pkg::KIND_LOAD) &&
                    (req_data.entry_index != 9'd0) &&
                    (32'(req_data.entry_index) < 32'(TABLE_DEPTH));

   always_comb begin
      mem_we = (state_ff == ST_CLEAR) || load_ok;
      mem_wa = (state_ff == ST_CLEAR) ? clr_ff : AW'(req_data.entry_index);
      if (state_ff == ST_CLEAR) begin
         mem_wd = '0;
      end else begin
         mem_wd.code      = req_data.codepoint;
         mem_wd.off_x     = req_data.glyph_offset_x;
         mem_wd.off_y     = req_data.glyph_offset_y;
         mem_wd.width     = req_data.glyph_width;
         mem_wd.height    = req_data.glyph_height;
         mem_wd.advance   = req_data.glyph_advance;
         mem_wd.tc_left   = req_data.texture_left;
         mem_wd.tc_right  = req_data.texture_right;
         mem_wd.tc_top    = req_data.texture_top;
         mem_wd.tc_bottom = req_data.texture_bottom;
      end
      mem_re = (state_ff == ST_SEARCH) && !end_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[scan_ff];
      end
   end

   // 16-bit wrapping pixel arithmetic on the matched entry
   always_comb begin
      left     = ent_ff.off_x + pen_ff;
      right    = ent_ff.width + left;
      down     = ent_ff.off_y;
      up       = ent_ff.height + down;
      pen_next = pen_ff + ent_ff.advance;
      pen_eff  = (req_data.kind == glq_pkg::KIND_NEW_STRING) ? 16'sd0 : pen_ff;
   end

   always_comb begin
      div_ctl.go    = (state_ff == ST_CALC);
      div_ctl.use_y = (op_ff == OP_DOWN) || (op_ff == OP_UP);
      unique case (op_ff)
         OP_LEFT:  div_ctl.px = left;
         OP_RIGHT: div_ctl.px = right;
         OP_DOWN:  div_ctl.px = down;
         OP_UP:    div_ctl.px = up;
         default:  div_ctl.px = left;
      endcase
   end

   glq_scale_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .res   (div_res)
   );

   always_comb begin
      unique case (corner_ff)
         CORNER_UPLEFT:    begin is_left = 1'b1; is_up = 1'b1; end
         CORNER_DOWNLEFT:  begin is_left = 1'b1; is_up = 1'b0; end
         CORNER_UPRIGHT:   begin is_left = 1'b0; is_up = 1'b1; end
         CORNER_DOWNRIGHT: begin is_left = 1'b0; is_up = 1'b0; end
         CORNER_UPRIGHT2:  begin is_left = 1'b0; is_up = 1'b1; end
         CORNER_DOWNLEFT2: begin is_left = 1'b1; is_up = 1'b0; end
         default:          begin is_left = 1'b1; is_up = 1'b1; end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      end_in        = end_ff;
      cmp_in        = 1'b0;
      cmp_end_in    = cmp_end_ff;
      cp_in         = cp_ff;
      pen_in        = pen_ff;
      ent_in        = ent_ff;
      op_in         = op_ff;
      corner_in     = corner_ff;
      xl_in         = xl_ff;
      xr_in         = xr_ff;
      yd_in         = yd_ff;
      yu_in         = yu_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  glq_pkg::KIND_GLYPH, glq_pkg::KIND_NEW_STRING: begin
                     pen_in = pen_eff;
                     cp_in  = req_data.codepoint;
                     if (req_data.codepoint == 21'd0) begin
                        rsp_strobe_in         = 1'b1;
                        rsp_data_in           = '0;
                        rsp_data_in.last      = 1'b1;
                        rsp_data_in.pen_after = pen_eff;
                     end else begin
                        state_in = ST_SEARCH;
                        scan_in  = AW'(1);
                        end_in   = 1'b0;
                     end
                  end
                  default: begin
                     // loads go straight to the table; unused kind is dropped
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (!end_ff) begin
               scan_in    = scan_ff + 1'b1;
               end_in     = (scan_ff == AW'(TABLE_DEPTH - 1));
               cmp_in     = 1'b1;
               cmp_end_in = (scan_ff == AW'(TABLE_DEPTH - 1));
            end
            // rd_data_ff holds the slot read in the previous cycle
            if (cmp_ff) begin
               priority if (rd_data_ff.code == cp_ff) begin
                  ent_in   = rd_data_ff;
                  op_in    = OP_LEFT;
                  state_in = ST_CALC;
               end else if ((rd_data_ff.code == 21'd0) || cmp_end_ff) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in           = '0;
                  rsp_data_in.last      = 1'b1;
                  rsp_data_in.pen_after = pen_ff;
                  state_in              = ST_IDLE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_CALC: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_res.done) begin
               unique case (op_ff)
                  OP_LEFT:  xl_in = div_res.quot;
                  OP_RIGHT: xr_in = div_res.quot;
                  OP_DOWN:  yd_in = div_res.quot;
                  OP_UP:    yu_in = div_res.quot;
                  default:  xl_in = div_res.quot;
               endcase
               if (op_ff == OP_UP) begin
                  corner_in = CORNER_UPLEFT;
                  state_in  = ST_EMIT;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_CALC;
               end
            end
         end
         ST_EMIT: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.corner    = corner_ff;
            rsp_data_in.vertex_x  = is_left ? xl_ff : xr_ff;
            rsp_data_in.vertex_y  = is_up ? yu_ff : yd_ff;
            rsp_data_in.vertex_z  = glq_pkg::LAYER_DEPTH;
            rsp_data_in.vertex_s  = is_left ? ent_ff.tc_left : ent_ff.tc_right;
            rsp_data_in.vertex_t  = is_up ? ent_ff.tc_top : ent_ff.tc_bottom;
            rsp_data_in.found     = 1'b1;
            rsp_data_in.last      = (corner_ff == CORNER_DOWNLEFT2);
            rsp_data_in.pen_after = pen_next;
            if (corner_ff == CORNER_DOWNLEFT2) begin
               pen_in   = pen_next;
               state_in = ST_IDLE;
            end else begin
               corner_in = corner_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         end_ff        <= 1'b0;
         cmp_ff        <= 1'b0;
         pen_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         end_ff        <= end_in;
         cmp_ff        <= cmp_in;
         pen_ff        <= pen_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      scan_ff     <= scan_in;
      cmp_end_ff  <= cmp_end_in;
      cp_ff       <= cp_in;
      ent_ff      <= ent_in;
      op_ff       <= op_in;
      corner_ff   <= corner_in;
      xl_ff       <= xl_in;
      xr_ff       <= xr_in;
      yd_ff       <= yd_in;
      yu_ff       <= yu_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> rtl/glq_checker.sv
// Port-level checks of the glyph quad layout core, bound into glyph_quad_layout_core.
module glq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input glq_pkg::glq_req_type req_data,
   input logic                 rsp_strobe,
   input glq_pkg::glq_rsp_type rsp_data
);

   // a result strobe is only allowed when the past sample shows busy or start high
   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("result strobe with no transaction in flight");

   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |-> rsp_data.last)
      else $error("not-found result without last flag");

   // vertices of one quad come back to back
   a_quad_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("gap inside a vertex burst");

   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found && !rsp_data.last) |=>
         (rsp_data.corner == 3'($past(rsp_data.corner) + 3'd1)))
      else $error("vertex corner out of order");

   a_layer: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |-> (rsp_data.vertex_z == glq_pkg::LAYER_DEPTH))
      else $error("vertex layer is not the fixed depth");

endmodule

bind glyph_quad_layout_core glq_checker u_glq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
